### hdl/kms_pkg.sv
// kms_pkg: shared types and constants of the k-way merge selector
// request actions, result status codes, sequencer states and compare-unit control
// no dependencies

package kms_pkg;

  // fixed field widths of the stream channels
  localparam int ACT_W       = 2;
  localparam int ST_W        = 3;
  localparam int RUN_FW      = 3;
  localparam int VAL_W       = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - RUN_FW;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_POP   = 2'd2,
    ACT_CLEAR = 2'd3
  } kms_action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_REFILL = 3'd1,
    ST_DONE   = 3'd2,
    ST_FULL   = 3'd3,
    ST_CLOSED = 3'd4
  } kms_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } kms_state_t;

  // control of the shared minimum unit
  typedef struct packed {
    logic clr;
    logic en;
  } kms_cmp_ctl_t;

endpackage

### hdl/kms_buf_ram.sv
// kms_buf_ram: word store for all run buffers, one write and one read port
// read data is registered; no reset on contents
// depends on nothing

module kms_buf_ram #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 128,
  parameter int AW         = 7
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic signed [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/kms_min_unit.sv
// kms_min_unit: shared signed compare unit holding the running minimum of a scan
// strict less-than keeps the earlier (lower) run on ties
// depends on kms_pkg

module kms_min_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int RW         = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kms_pkg::kms_cmp_ctl_t        ctl,
  input  logic signed [DATA_WIDTH-1:0] cand_val,
  input  logic [RW-1:0]                cand_run,
  output logic                         found,
  output logic signed [DATA_WIDTH-1:0] best_val,
  output logic [RW-1:0]                best_run
);

  import kms_pkg::*;

  logic                         found_r;
  logic signed [DATA_WIDTH-1:0] best_val_r;
  logic [RW-1:0]                best_run_r;
  logic                         take;

  // candidate wins when nothing held yet or strictly smaller
  assign take = ctl.en && (!found_r || (cand_val < best_val_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  // held minimum and its run
  always_ff @(posedge clk) begin
    if (!ctl.clr && take) begin
      best_val_r <= cand_val;
      best_run_r <= cand_run;
    end
  end

  assign found    = found_r;
  assign best_val = best_val_r;
  assign best_run = best_run_r;

endmodule

### hdl/kway_merge_selector.sv
// kway_merge_selector: top level of the k-way merge selector
// load, close and clear: executed in S_EXEC, whose result goes straight into the result register
// pop: S_EXEC, then S_SCAN (one head read and compare per run), S_DRAIN to drain the compare
//   and S_UPDATE to advance the winner; a refill answer leaves S_SCAN at the first open empty run
// in_tready returns the cycle after the result is taken; no new request is taken before then
// reset (rst_n low, synchronous): all runs open and empty; buffer words are not cleared
//
// depends on kms_pkg, kms_buf_ram, kms_min_unit

module kway_merge_selector #(
  parameter int RUNS         = 8,
  parameter int BUFFER_DEPTH = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kms_pkg::IN_TDATA_W-1:0]     in_tdata,   // run[2:0], value[34:3], zero pad
  input  logic [kms_pkg::ACT_W-1:0]          in_tuser,   // action[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kms_pkg::OUT_TDATA_W-1:0]    out_tdata,  // min_value[31:0], source_run[34:32], pad
  output logic [kms_pkg::ST_W-1:0]           out_tuser   // status[2:0]
);

  import kms_pkg::*;

  localparam int RW    = $clog2(RUNS);
  localparam int PW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW    = $clog2(BUFFER_DEPTH + 1);
  localparam int DEPTH = RUNS * BUFFER_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // sequencer and request registers
  kms_state_t               state_r, state_nxt;
  kms_action_t              act_r;
  logic [RUN_FW-1:0]        run_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [RW-1:0]            idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [RW-1:0]            pend_run_r;

  // per-run state
  logic [CW-1:0]            cnt_r  [RUNS];
  logic [CW-1:0]            cnt_nxt [RUNS];
  logic [PW-1:0]            rptr_r [RUNS];
  logic [PW-1:0]            rptr_nxt [RUNS];
  logic [RUNS-1:0]          fin_r, fin_nxt;

  // result register
  logic                     out_valid_r;
  kms_status_t              out_status_r;
  logic [VAL_W-1:0]         out_value_r;
  logic [RUN_FW-1:0]        out_src_r;

  // result of the current step
  logic                     res_valid;
  kms_status_t              res_status;
  logic [VAL_W-1:0]         res_value;
  logic [RUN_FW-1:0]        res_src;

  // datapath
  logic                     run_ok;
  logic [RW-1:0]            run_idx;
  logic [RW-1:0]            sel_idx;
  logic [CW-1:0]            cnt_sel;
  logic [PW-1:0]            rptr_sel;
  logic                     fin_sel;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            ram_raddr;
  logic signed [DATA_WIDTH-1:0] ram_wdata;
  logic signed [DATA_WIDTH-1:0] ram_rdata;
  kms_cmp_ctl_t             cmp_ctl;
  logic                     best_found;
  logic signed [DATA_WIDTH-1:0] best_val;
  logic [RW-1:0]            best_run;

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;

  assign run_ok  = (int'(run_r) < RUNS);
  assign run_idx = RW'(run_r);

  // one run-state read port, steered by the sequencer
  always_comb begin
    case (state_r)
      S_EXEC:  sel_idx = run_idx;
      S_SCAN:  sel_idx = idx_r;
      default: sel_idx = best_run;
    endcase
  end

  assign cnt_sel  = cnt_r[sel_idx];
  assign rptr_sel = rptr_r[sel_idx];
  assign fin_sel  = fin_r[sel_idx];

  // buffer addresses: run base plus offset
  assign ram_waddr = AW'(int'(run_idx) * BUFFER_DEPTH + int'(cnt_sel));
  assign ram_raddr = AW'(int'(idx_r) * BUFFER_DEPTH + int'(rptr_sel));
  assign ram_wdata = DATA_WIDTH'(val_r);

  kms_buf_ram #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kms_min_unit #(
    .DATA_WIDTH (DATA_WIDTH),
    .RW         (RW)
  ) u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cmp_ctl),
    .cand_val (ram_rdata),
    .cand_run (pend_run_r),
    .found    (best_found),
    .best_val (best_val),
    .best_run (best_run)
  );

  // next state, run state updates and result
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pend_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rptr_nxt   = rptr_r;
    fin_nxt    = fin_r;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    res_src    = '0;
    ram_we     = 1'b0;
    cmp_ctl.clr = 1'b0;
    cmp_ctl.en  = pend_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        case (act_r)
          ACT_LOAD: begin
            res_valid = 1'b1;
            res_src   = run_r;
            if (!run_ok || fin_sel) begin
              res_status = ST_CLOSED;
            end else if (int'(cnt_sel) >= BUFFER_DEPTH) begin
              res_status = ST_FULL;
            end else begin
              ram_we            = 1'b1;
              cnt_nxt[run_idx]  = CW'(int'(cnt_sel) + 1);
            end
          end
          ACT_CLOSE: begin
            res_valid = 1'b1;
            res_src   = run_r;
            if (!run_ok) begin
              res_status = ST_CLOSED;
            end else begin
              fin_nxt[run_idx] = 1'b1;
            end
          end
          ACT_CLEAR: begin
            res_valid = 1'b1;
            fin_nxt   = '0;
            for (int r = 0; r < RUNS; r++) begin
              cnt_nxt[r]  = '0;
              rptr_nxt[r] = '0;
            end
          end
          ACT_POP: begin
            idx_nxt     = '0;
            cmp_ctl.clr = 1'b1;
            state_nxt   = S_SCAN;
          end
          default: begin
            res_valid = 1'b1;
          end
        endcase
      end

      // one run per cycle: refill check, then head read for the compare
      S_SCAN: begin
        if (!fin_sel && (cnt_sel == '0)) begin
          res_valid  = 1'b1;
          res_status = ST_REFILL;
          res_src    = RUN_FW'(idx_r);
          state_nxt  = S_IDLE;
        end else begin
          pend_nxt = (cnt_sel != '0);
          if (int'(idx_r) == RUNS - 1) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = RW'(int'(idx_r) + 1);
          end
        end
      end

      // last head word reaches the compare unit
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end

      // report the minimum and advance its run
      S_UPDATE: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
        if (!best_found) begin
          res_status = ST_DONE;
        end else begin
          res_value = VAL_W'(best_val);
          res_src   = RUN_FW'(best_run);
          if (int'(rptr_sel) + 1 >= int'(cnt_sel)) begin
            rptr_nxt[best_run] = '0;
            cnt_nxt[best_run]  = '0;
          end else begin
            rptr_nxt[best_run] = PW'(int'(rptr_sel) + 1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      fin_r       <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < RUNS; r++) begin
        cnt_r[r]  <= '0;
        rptr_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      fin_r   <= fin_nxt;
      cnt_r   <= cnt_nxt;
      rptr_r  <= rptr_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, pending read tag and result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r <= kms_action_t'(in_tuser);
      run_r <= in_tdata[RUN_FW-1:0];
      val_r <= in_tdata[RUN_FW +: VAL_W];
    end
    if (pend_nxt) begin
      pend_run_r <= idx_r;
    end
    if (res_valid) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_src_r    <= res_src;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_src_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

### hdl/kms_checker.sv
// kms_checker: port-level checks of the k-way merge selector, bound to the top level
// depends on kms_pkg and kway_merge_selector

module kms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [kms_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [kms_pkg::ACT_W-1:0]       in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kms_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [kms_pkg::ST_W-1:0]        out_tuser
);

  import kms_pkg::*;

  // a waiting result blocks new requests
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while a result is pending");

  // a taken request leaves the block busy, not ready, in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after a request was taken");

  // anything but a plain ok carries a zero word
  a_zero_value_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata[VAL_W-1:0] == '0))
    else $error("nonzero min_value with a non-ok status");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind kway_merge_selector kms_checker u_kms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/kms_merge_checker.sv
`timescale 1ns / 100ps
// kms_merge_checker: watches both streams of the k-way merge selector
// keeps its own copy of the run buffers, predicts every result and compares it
// depends on kms_pkg

module kms_merge_checker #(
  parameter int RUNS         = 8,
  parameter int BUFFER_DEPTH = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [kms_pkg::IN_TDATA_W-1:0]  in_tdata,   // run[2:0], value[34:3], zero pad
  input  logic [kms_pkg::ACT_W-1:0]       in_tuser,   // action[1:0]
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [kms_pkg::OUT_TDATA_W-1:0] out_tdata,  // min_value[31:0], source_run[34:32], pad
  input  logic [kms_pkg::ST_W-1:0]        out_tuser,  // status[2:0]
  output int                              mismatches,
  output int                              pending,
  output int                              compared
);
  import kms_pkg::*;

  typedef struct {
    kms_status_t        status;
    logic [VAL_W-1:0]   min_value;
    logic [RUN_FW-1:0]  source_run;
  } merge_result_t;

  // shadow copy of the run buffers and their bookkeeping
  logic signed [DATA_WIDTH-1:0] run_words [RUNS][BUFFER_DEPTH];
  int unsigned                  head_idx  [RUNS];
  int unsigned                  fill      [RUNS];
  bit                           run_closed[RUNS];
  merge_result_t                expected_q[$];

  initial begin
    mismatches = 0;
    compared   = 0;
    pending    = 0;
  end

  function automatic void clear_runs();
    for (int r = 0; r < RUNS; r++) begin
      head_idx[r]   = 0;
      fill[r]       = 0;
      run_closed[r] = 1'b0;
    end
  endfunction

  // result of one request, updating the shadow state
  function automatic merge_result_t next_result(input kms_action_t act,
                                                input logic [RUN_FW-1:0] run,
                                                input logic [VAL_W-1:0] value);
    merge_result_t                res;
    logic signed [VAL_W-1:0]      word32;
    logic signed [DATA_WIDTH-1:0] best_word;
    int                           best;
    res = '{status: ST_OK, min_value: '0, source_run: run};
    best = -1;
    best_word = '0;
    case (act)
      ACT_LOAD: begin
        if (int'(run) >= RUNS || run_closed[run]) begin
          res.status = ST_CLOSED;
        end else if (fill[run] >= BUFFER_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          word32 = value;
          run_words[run][fill[run]] = word32;
          fill[run]++;
        end
      end
      ACT_CLOSE: begin
        if (int'(run) >= RUNS) res.status = ST_CLOSED;
        else run_closed[run] = 1'b1;
      end
      ACT_CLEAR: begin
        clear_runs();
        res.source_run = '0;
      end
      default: begin
        res.source_run = '0;
        // any open run with nothing buffered stalls the merge
        for (int r = 0; r < RUNS; r++) begin
          if (!run_closed[r] && fill[r] == 0) begin
            res.status     = ST_REFILL;
            res.source_run = RUN_FW'(r);
            return res;
          end
        end
        // signed minimum over the head words, lowest run wins a tie
        for (int r = 0; r < RUNS; r++) begin
          if (fill[r] != 0 && head_idx[r] < fill[r]) begin
            if (best < 0 || run_words[r][head_idx[r]] < best_word) begin
              best      = r;
              best_word = run_words[r][head_idx[r]];
            end
          end
        end
        if (best < 0) begin
          res.status = ST_DONE;
        end else begin
          word32         = best_word;
          res.min_value  = word32;
          res.source_run = RUN_FW'(best);
          head_idx[best]++;
          // drained buffer starts over from position zero
          if (head_idx[best] >= fill[best]) begin
            head_idx[best] = 0;
            fill[best]     = 0;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_error(input string msg);
    if (mismatches < 40) $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  // sample both channels at every rising edge
  always @(posedge clk) begin
    merge_result_t want;
    if (!rst_n) begin
      clear_runs();
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(next_result(kms_action_t'(in_tuser), in_tdata[RUN_FW-1:0],
                                         in_tdata[RUN_FW +: VAL_W]));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result with no request pending: status %0h data %0h",
                                 out_tuser, out_tdata));
        end else begin
          want = expected_q.pop_front();
          if (out_tuser !== want.status)
            report_error($sformatf("result %0d status %0h, expected %0h",
                                   compared, out_tuser, want.status));
          if (out_tdata[VAL_W-1:0] !== want.min_value)
            report_error($sformatf("result %0d min_value %0h, expected %0h",
                                   compared, out_tdata[VAL_W-1:0], want.min_value));
          if (out_tdata[VAL_W +: RUN_FW] !== want.source_run)
            report_error($sformatf("result %0d source_run %0d, expected %0d",
                                   compared, out_tdata[VAL_W +: RUN_FW], want.source_run));
          compared++;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for the k-way merge selector
// drives directed and random merge rounds with random gaps on both streams
// depends on kms_pkg, kway_merge_selector and kms_merge_checker

module tb;
  import kms_pkg::*;

  localparam int RUNS            = 8;
  localparam int BUFFER_DEPTH    = 16;
  localparam int DATA_WIDTH      = 32;
  localparam int TARGET_REQUESTS = 800;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 2 * (RUNS + 3);
  localparam int LONG_HOLD       = 600;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]       in_tuser   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;

  int mismatches;
  int pending;
  int compared;
  int sent     = 0;
  int rounds   = 0;
  int cycles   = 0;
  bit steady   = 1'b0;

  kway_merge_selector #(
    .RUNS(RUNS), .BUFFER_DEPTH(BUFFER_DEPTH), .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  kms_merge_checker #(
    .RUNS(RUNS), .BUFFER_DEPTH(BUFFER_DEPTH), .DATA_WIDTH(DATA_WIDTH)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .mismatches(mismatches), .pending(pending), .compared(compared)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // data word: extremes, small values that tie, or anything
  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return VAL_W'($urandom_range(0, 7) - 3);
      default: return $urandom;
    endcase
  endfunction

  // one request on the input stream, then an optional gap
  task automatic send_request(input kms_action_t act, input logic [RUN_FW-1:0] run,
                              input logic [VAL_W-1:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W - VAL_W - RUN_FW){1'b0}}, value, run};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // well-formed round: clear, fill runs with ascending words, close most, pop them out,
  // topping up and closing the runs left open along the way
  task automatic merge_round();
    int               r;
    int               n;
    int               total;
    int               pops;
    bit               left_open [RUNS];
    logic [VAL_W-1:0] word;
    rounds++;
    steady = ($urandom_range(0, 4) == 0);
    send_request(ACT_CLEAR, RUN_FW'($urandom), $urandom);
    total = 0;
    for (r = 0; r < RUNS; r++) begin
      case ($urandom_range(0, 19))
        0, 1:    n = $urandom_range(BUFFER_DEPTH - 2, BUFFER_DEPTH + 2);
        2, 3, 4: n = 0;
        default: n = $urandom_range(1, 4);
      endcase
      word = pick_word();
      for (int i = 0; i < n; i++) begin
        send_request(ACT_LOAD, RUN_FW'(r), word);
        word = word + $urandom_range(0, 2);
      end
      total += n;
      left_open[r] = ($urandom_range(0, 3) == 0);
      if (!left_open[r]) send_request(ACT_CLOSE, RUN_FW'(r), $urandom);
    end
    pops = 0;
    while (pops < total + 3) begin
      n = $urandom_range(2, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_request(ACT_LOAD, RUN_FW'($urandom), pick_word());
        send_request(ACT_POP, RUN_FW'($urandom), $urandom);
      end
      pops += n;
      for (r = 0; r < RUNS; r++) begin
        if (left_open[r] && $urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, 2);
          for (int i = 0; i < n; i++) send_request(ACT_LOAD, RUN_FW'(r), pick_word());
          total += n;
        end
        if (left_open[r] && $urandom_range(0, 6) == 0) begin
          send_request(ACT_CLOSE, RUN_FW'(r), $urandom);
          left_open[r] = 1'b0;
        end
      end
    end
  endtask

  // unstructured requests
  task automatic noise_burst();
    int n;
    steady = 1'b0;
    n = $urandom_range(3, 10);
    repeat (n) send_request(kms_action_t'($urandom_range(0, 3)), RUN_FW'($urandom), $urandom);
  endtask

  // receiver: random stalls, with one long hold-off that backs up the block
  initial begin
    int turn;
    int stall;
    turn = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16)) @(posedge clk);
      stall = (turn == 30) ? LONG_HOLD : idle_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      turn++;
    end
  end

  // stimulus and verdict
  initial begin
    int base;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop with every run open and empty asks for run 0
    send_request(ACT_POP, 3'd0, '0);
    // close, close again, then a load into the closed run
    send_request(ACT_CLOSE, 3'd0, '0);
    send_request(ACT_CLOSE, 3'd0, 32'hffff_ffff);
    send_request(ACT_LOAD, 3'd0, 32'h0000_1234);
    // extremes, and a tie on the most negative word
    send_request(ACT_LOAD, 3'd1, 32'h8000_0000);
    send_request(ACT_LOAD, 3'd2, 32'h7fff_ffff);
    send_request(ACT_LOAD, 3'd3, 32'h8000_0000);
    send_request(ACT_LOAD, 3'd3, 32'hffff_ffff);
    for (int r = 4; r < RUNS; r++) send_request(ACT_CLOSE, RUN_FW'(r), '0);
    // tie goes to run 1, which drains and then wants a refill
    send_request(ACT_POP, 3'd7, '0);
    send_request(ACT_POP, 3'd0, '0);
    send_request(ACT_CLOSE, 3'd1, '0);
    send_request(ACT_POP, 3'd0, '0);
    // closed runs with words still buffered keep popping until done
    send_request(ACT_CLOSE, 3'd3, '0);
    send_request(ACT_CLOSE, 3'd2, '0);
    send_request(ACT_POP, 3'd0, '0);
    send_request(ACT_POP, 3'd0, '0);
    send_request(ACT_POP, 3'd0, '0);
    // clear reopens everything
    send_request(ACT_CLEAR, 3'd5, 32'hdead_beef);
    send_request(ACT_POP, 3'd0, '0);
    send_request(ACT_LOAD, 3'd7, 32'h0000_0000);

    base = sent;
    while (sent < base + TARGET_REQUESTS) begin
      if ($urandom_range(0, 9) < 7) merge_round();
      else noise_burst();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests in %0d merge rounds plus noise, %0d results checked",
             sent, rounds, compared);
    $display("loads, closes, pops, clears, full and closed runs, refills, ties, long stall");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
